// File: hdl/bshc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bshc_pkg;

   // brew sequence phases, as shown on the result word
   typedef enum logic [2:0] {
      PH_OFF        = 3'd0,
      PH_PREINF_ON  = 3'd1,
      PH_PREINF_OFF = 3'd2,
      PH_BREW       = 3'd3,
      PH_STANDBY    = 3'd4
   } phase_type;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      REG_SETPOINT     = 3'd0,
      REG_BREW_SEC     = 3'd1,
      REG_PREINF_EN    = 3'd2,
      REG_PREINF_ON    = 3'd3,
      REG_PREINF_OFF   = 3'd4,
      REG_TEMP_LOCK    = 3'd5,
      REG_STANDBY_SEC  = 3'd6
   } reg_index_type;

   localparam int DUTY_DIVISOR = 3;
   localparam int DUTY_W       = 2;

   // quarter-degree thresholds
   localparam int OVERHEAT_Q   = 440;
   localparam int THIN_RANGE_Q = 40;
   localparam int IN_RANGE_Q   = 8;

   localparam int MS_PER_SEC   = 1000;
   localparam int MS_PER_HALF  = 500;

   // reset values of the registers
   localparam logic [6:0]  RST_SETPOINT    = 7'd96;
   localparam logic [14:0] RST_BREW_MS     = 15'd6000;
   localparam logic        RST_PREINF_EN   = 1'b1;
   localparam logic [13:0] RST_PREINF_ON   = 14'd3000;
   localparam logic [12:0] RST_PREINF_HALF = 13'd1500;
   localparam logic [14:0] RST_PREINF_OFF  = 15'd10000;
   localparam logic        RST_TEMP_LOCK   = 1'b1;
   localparam logic [25:0] RST_STANDBY_MS  = 26'd900000;

   // heater curve breakpoints on the error, quarter degrees
   localparam int CURVE_LOW_Q  = 1;    // at or below: 0 percent
   localparam int CURVE_RAMP_Q = 40;   // up to here: 1 percent
   localparam int CURVE_MID_Q  = 100;  // 80 percent here
   localparam int CURVE_TOP_Q  = 200;  // 100 percent from here
   localparam int CURVE_MID_PCT = 80;
   // floor(79*x/60) = (x * RAMP_RECIP) >> RAMP_SHIFT for x <= 60
   localparam logic [16:0] RAMP_RECIP = 17'd86290;
   localparam int          RAMP_SHIFT = 16;
   // floor(x/5) = (x * FIVE_RECIP) >> FIVE_SHIFT for x <= 100
   localparam logic [7:0]  FIVE_RECIP = 8'd205;
   localparam int          FIVE_SHIFT = 10;

endpackage

`default_nettype wire

// File: hdl/brew_sequencer_heater_control.sv
`timescale 1ns / 1ps
`default_nettype none

// Brew sequencer and boiler heater control. Each request word is one control tick
// (timestamp, thermocouple word, brew button toggle, power switch write); each tick
// gives exactly one response word with the pump level, heater percent, decoded
// temperature, phase and fault flags. A new word is taken every clock unless the
// response register is stalled: the word passes an input register, one pass of
// shallow logic and a response register, and the response register alone holds
// back the input side when rsp_tready is low. The user must write registers on the
// csr port only while no tick is in flight; the block itself does not enforce it.
// The ms limits are worked out from the second counts at write time.

module brew_sequencer_heater_control
   import bshc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: now_ms[31:0], sensor_word[47:32], brew_press[48], power_write[49],
   //            power_value[50], zero fill[55:51]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,
   // rsp_tdata: pump_on[0], heater_percent[7:1], temp_in_range[8],
   //            temperature_q[21:9], phase[24:22], powered[25], sensor_fault[26],
   //            zero fill[31:27]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // configuration
   logic [6:0]  setpoint_ff;
   logic [14:0] brew_ms_ff;
   logic        preinf_en_ff;
   logic [13:0] preinf_on_ms_ff;
   logic [12:0] preinf_half_ms_ff;
   logic [14:0] preinf_off_ms_ff;
   logic        temp_lock_ff;
   logic [25:0] standby_ms_ff;

   // input register
   logic        in_valid_ff;
   logic [31:0] in_now_ff;
   logic [15:0] in_word_ff;
   logic        in_press_ff;
   logic        in_pwr_wr_ff;
   logic        in_pwr_val_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic [31:0] idle_start_ff, idle_start_in;
   logic        request_ff, request_in;
   logic        power_flag_ff, power_flag_in;
   logic        pump_ff, pump_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic        advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff       <= RST_SETPOINT;
         brew_ms_ff        <= RST_BREW_MS;
         preinf_en_ff      <= RST_PREINF_EN;
         preinf_on_ms_ff   <= RST_PREINF_ON;
         preinf_half_ms_ff <= RST_PREINF_HALF;
         preinf_off_ms_ff  <= RST_PREINF_OFF;
         temp_lock_ff      <= RST_TEMP_LOCK;
         standby_ms_ff     <= RST_STANDBY_MS;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SETPOINT:    setpoint_ff  <= csr_data[6:0];
            REG_BREW_SEC:    brew_ms_ff   <= 15'(csr_data[4:0]) * 15'(MS_PER_SEC);
            REG_PREINF_EN:   preinf_en_ff <= csr_data[0];
            REG_PREINF_ON: begin
               preinf_on_ms_ff   <= 14'(csr_data[3:0]) * 14'(MS_PER_SEC);
               preinf_half_ms_ff <= 13'(csr_data[3:0]) * 13'(MS_PER_HALF);
            end
            REG_PREINF_OFF:  preinf_off_ms_ff <= 15'(csr_data[4:0]) * 15'(MS_PER_SEC);
            REG_TEMP_LOCK:   temp_lock_ff     <= csr_data[0];
            REG_STANDBY_SEC: standby_ms_ff    <= 26'(csr_data) * 26'(MS_PER_SEC);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_now_ff     <= req_tdata[31:0];
         in_word_ff    <= req_tdata[47:32];
         in_press_ff   <= req_tdata[48];
         in_pwr_wr_ff  <= req_tdata[49];
         in_pwr_val_ff <= req_tdata[50];
      end
   end

   always_comb begin
      logic              open_sensor;
      logic              fault;
      logic              in_range;
      logic signed [12:0] temp_q;
      logic signed [13:0] temp_w;
      logic signed [13:0] sp_q;
      logic signed [13:0] err;
      logic [31:0]       el_phase;
      logic [31:0]       el_idle;
      logic [31:0]       el_pump;
      logic [6:0]        ramp_x;
      logic [23:0]       ramp_p;
      logic [6:0]        top_x;
      logic [14:0]       top_p;
      logic [6:0]        power;

      request_in     = request_ff ^ in_press_ff;
      power_flag_in  = in_pwr_wr_ff ? in_pwr_val_ff : power_flag_ff;
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      idle_start_in  = idle_start_ff;
      pump_in        = pump_ff;

      open_sensor = in_word_ff[2];
      temp_q      = open_sensor ? 13'sd0 : $signed(in_word_ff[15:3]);
      temp_w      = 14'(temp_q);
      sp_q        = $signed({5'd0, setpoint_ff, 2'd0});
      in_range    = (temp_w >= sp_q - 14'sd8) && (temp_w <= sp_q + 14'sd8);

      el_phase = in_now_ff - phase_start_ff;
      el_idle  = in_now_ff - idle_start_ff;

      // request withdrawn: back to off, pump stops
      if (!request_in && phase_ff != PH_STANDBY) begin
         pump_in  = 1'b0;
         phase_in = PH_OFF;
      end

      case (phase_in)
         PH_OFF: begin
            if (request_in) begin
               if (in_range || !temp_lock_ff) begin
                  phase_start_in = in_now_ff;
                  idle_start_in  = in_now_ff;
                  phase_in       = preinf_en_ff ? PH_PREINF_ON : PH_BREW;
               end else begin
                  request_in = 1'b0;
               end
            end else if (!power_flag_in || el_idle > 32'(standby_ms_ff)) begin
               phase_in      = PH_STANDBY;
               power_flag_in = 1'b0;
            end
         end
         PH_PREINF_ON: begin
            if (el_phase < 32'(preinf_on_ms_ff)) begin
               pump_in = 1'b1;
            end else begin
               phase_in       = PH_PREINF_OFF;
               phase_start_in = in_now_ff;
            end
         end
         PH_PREINF_OFF: begin
            if (el_phase < 32'(preinf_off_ms_ff)) begin
               pump_in = 1'b0;
            end else begin
               phase_in       = PH_BREW;
               phase_start_in = in_now_ff;
            end
         end
         PH_BREW: begin
            if (el_phase < 32'(brew_ms_ff)) begin
               pump_in = 1'b1;
            end else begin
               pump_in    = 1'b0;
               phase_in   = PH_OFF;
               request_in = 1'b0;
            end
         end
         PH_STANDBY: begin
            if (power_flag_in) begin
               idle_start_in = in_now_ff;
               phase_in      = PH_OFF;
            end
         end
         default: ;
      endcase

      // heater curve on the error, reciprocal multiplies stand in for the divides
      err    = sp_q - temp_w;
      ramp_x = 7'(err - 14'(CURVE_RAMP_Q));
      ramp_p = 24'(ramp_x) * 24'(RAMP_RECIP);
      top_x  = 7'(err - 14'(CURVE_MID_Q));
      top_p  = 15'(top_x) * 15'(FIVE_RECIP);
      if (err <= 14'(CURVE_LOW_Q)) begin
         power = 7'd0;
      end else if (err <= 14'(CURVE_RAMP_Q)) begin
         power = 7'd1;
      end else if (err <= 14'(CURVE_MID_Q)) begin
         power = 7'd1 + ramp_p[RAMP_SHIFT +: 7];
      end else if (err <= 14'(CURVE_TOP_Q)) begin
         power = 7'(CURVE_MID_PCT) + 7'(top_p[FIVE_SHIFT +: 5]);
      end else begin
         power = 7'd100;
      end
      if (err > 14'sd0 && err <= 14'(THIN_RANGE_Q) && duty_ff != '0) begin
         power = 7'd0;
      end

      el_pump = in_now_ff - phase_start_in;
      fault   = open_sensor || (temp_w > 14'(OVERHEAT_Q));
      if (fault || phase_in == PH_STANDBY) begin
         power = 7'd0;
      end else if (phase_in inside {PH_PREINF_ON, PH_BREW} ||
                   (phase_in == PH_PREINF_OFF && el_pump < 32'(preinf_half_ms_ff))) begin
         power = 7'd100;
      end

      duty_in = (32'(duty_ff) + 32'd1 >= 32'(DUTY_DIVISOR)) ? '0 : duty_ff + 1'b1;

      rsp_data_in = {5'd0, fault, power_flag_in, phase_in, temp_q, in_range, power,
                     pump_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_OFF;
         phase_start_ff <= '0;
         idle_start_ff  <= '0;
         request_ff     <= 1'b0;
         power_flag_ff  <= 1'b1;
         pump_ff        <= 1'b0;
         duty_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff       <= phase_in;
            phase_start_ff <= phase_start_in;
            idle_start_ff  <= idle_start_in;
            request_ff     <= request_in;
            power_flag_ff  <= power_flag_in;
            pump_ff        <= pump_in;
            duty_ff        <= duty_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/bshc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bshc_checker
   import bshc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // heater never above full power
   a_heater_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:1] <= 7'd100))
      else $error("heater percent above 100");

   // a fault always cuts the heater
   a_fault_cut: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[26]) |-> (rsp_tdata[7:1] == 7'd0))
      else $error("heater on during sensor fault");

   // standby means heater off and power flag cleared
   a_standby: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[24:22] == PH_STANDBY) |->
      (rsp_tdata[7:1] == 7'd0 && !rsp_tdata[25]))
      else $error("standby with heater or power on");

   // pump only runs inside a brew cycle
   a_pump_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |->
      (rsp_tdata[24:22] == PH_PREINF_ON || rsp_tdata[24:22] == PH_PREINF_OFF ||
       rsp_tdata[24:22] == PH_BREW))
      else $error("pump on outside brew cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response word dropped or changed while stalled");

endmodule

bind brew_sequencer_heater_control bshc_checker u_bshc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
